FILE: rtl/core/fms_pkg.sv
// Shared types, constants and helpers of the FIFO multi-server dispatcher.
`default_nettype none
package fms_pkg;

	localparam int NUM_SERVERS = 3;
	localparam int QUEUE_DEPTH = 128;

	localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int ACT_W = $clog2(NUM_SERVERS + 1);

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [2:0] {
		EV_QUEUED  = 3'd0,
		EV_DROPPED = 3'd1,
		EV_STARTED = 3'd2,
		EV_IDLE    = 3'd3,
		EV_SERVING = 3'd4
	} ev_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic             visit;
		logic             start;
		logic [SRV_W-1:0] idx;
		logic [15:0]      id;
		logic [15:0]      len;
		logic [15:0]      end_tk;
	} srv_cmd_t;

	typedef struct packed {
		logic        need;
		logic        any_serving;
		logic [15:0] job;
		logic [15:0] end_tk;
	} srv_view_t;

	// Zero counts as one server, values above the server count clamp to it.
	function automatic logic [ACT_W-1:0] active_servers(input logic [1:0] en);
		logic [ACT_W-1:0] n;
		if (en == 2'd0) begin
			n = ACT_W'(1);
		end else if (int'(en) > NUM_SERVERS) begin
			n = ACT_W'(NUM_SERVERS);
		end else begin
			n = ACT_W'(en);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fms_queue.sv
// Job FIFO: entry memory, head, tail and fill count, registered head read.
`default_nettype none
module fms_queue import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_cmd_t      cmd,
	input  logic [15:0] push_id,
	input  logic [15:0] push_len,
	output q_status_t   st,
	output logic [15:0] head_id,
	output logic [15:0] head_len
);

	logic [31:0]      mem_q [QUEUE_DEPTH];
	logic [31:0]      rd_q;
	logic [QA_W-1:0]  head_q;
	logic [QA_W-1:0]  tail_q;
	logic [CNT_W-1:0] count_q;
	logic [QA_W-1:0]  rd_addr;

	function automatic logic [QA_W-1:0] next_ptr(input logic [QA_W-1:0] p);
		return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + QA_W'(1);
	endfunction

	// Read ahead at the head the next cycle will see.
	assign rd_addr = cmd.pop ? next_ptr(head_q) : head_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail_q] <= {push_id, push_len};
		end
		if (cmd.push && (tail_q == rd_addr)) begin
			rd_q <= {push_id, push_len};
		end else begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= next_ptr(tail_q);
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				head_q  <= next_ptr(head_q);
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign st.empty = (count_q == '0);
	assign st.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_id  = rd_q[31:16];
	assign head_len = rd_q[15:0];

endmodule
`default_nettype wire

FILE: rtl/core/fms_servers.sv
// Server state: busy flags, current jobs, countdowns and end times.
`default_nettype none
module fms_servers import fms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  srv_cmd_t         cmd,
	input  logic [ACT_W-1:0] act,
	output srv_view_t        view
);

	logic        busy_q [NUM_SERVERS];
	logic [15:0] job_q  [NUM_SERVERS];
	logic [15:0] rem_q  [NUM_SERVERS];
	logic [15:0] end_q  [NUM_SERVERS];
	logic        need;

	assign need = !busy_q[cmd.idx] || (rem_q[cmd.idx] == 16'd0);

	always_comb begin
		view.any_serving = 1'b0;
		for (int i = 0; i < NUM_SERVERS; i++) begin
			if ((i < int'(act)) && busy_q[i] && (rem_q[i] != 16'd0)) begin
				view.any_serving = 1'b1;
			end
		end
		view.need   = need;
		view.job    = job_q[cmd.idx];
		view.end_tk = end_q[cmd.idx];
	end

	// Countdown for this tick is folded into the visit: saturate at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVERS; i++) begin
				busy_q[i] <= 1'b0;
				job_q[i]  <= '0;
				rem_q[i]  <= '0;
				end_q[i]  <= '0;
			end
		end else if (cmd.visit) begin
			if (need) begin
				if (cmd.start) begin
					busy_q[cmd.idx] <= 1'b1;
					job_q[cmd.idx]  <= cmd.id;
					rem_q[cmd.idx]  <= (cmd.len == 16'd0) ? 16'd0 : cmd.len - 16'd1;
					end_q[cmd.idx]  <= cmd.end_tk;
				end else begin
					busy_q[cmd.idx] <= 1'b0;
				end
			end else begin
				rem_q[cmd.idx] <= rem_q[cmd.idx] - 16'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fifo_multi_server_dispatcher.sv
// Top level of the FIFO multi-server dispatcher: request sequencer and result register.
`default_nettype none
// Job dispatcher with one FIFO and up to three servers. An arrive request
// queues a job (or reports it dropped when the FIFO is full) and gives one
// result. A tick request visits the enabled servers in index order, one
// server per cycle while the result register is not stalled, and gives one
// result per enabled server (1 to 3), the final one flagged with last. The
// FIFO has a single read port, which can hand out one head entry per cycle.
// A result register sits on the output, so the next request is taken in the
// cycle its predecessor issues its final result, even before that result is
// taken downstream. The user must write servers_enabled through cfg_wr_en
// and cfg_wr_data only while idle; the block itself does not enforce it.
// Zero means one server. The FIFO storage has no reset and needs no
// clearing pass: entries are read only after written.
module fifo_multi_server_dispatcher import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        opcode,
	input  logic [15:0] job_id,
	input  logic [15:0] service_len,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  server_index,
	output logic [2:0]  event_res,
	output logic [15:0] served_id,
	output logic [15:0] end_time,
	output logic [15:0] now_time,
	output logic        all_done,
	output logic        last
);

	logic [1:0]       cfg_q;
	logic [ACT_W-1:0] act;

	// request held while it is worked on
	logic             act_q;
	logic             op_s1;
	logic [15:0]      id_s1;
	logic [15:0]      len_s1;
	logic [SRV_W-1:0] idx_q;
	logic             done_q;
	logic [15:0]      tick_q;

	// result register
	logic             res_valid_q;
	logic [1:0]       res_idx_q;
	ev_t              res_ev_q;
	logic [15:0]      res_id_q;
	logic [15:0]      res_end_q;
	logic [15:0]      res_now_q;
	logic             res_done_q;
	logic             res_last_q;

	logic             req_accept;
	logic             step;
	logic             last_step;
	logic             done_sel;
	ev_t              ev;
	logic [15:0]      ev_id;
	logic [15:0]      ev_end;
	logic [15:0]      start_end;

	q_cmd_t           q_cmd;
	q_status_t        q_st;
	logic [15:0]      head_id;
	logic [15:0]      head_len;
	srv_cmd_t         s_cmd;
	srv_view_t        s_view;

	assign act = active_servers(cfg_q);

	// Advance one result whenever the result register is free or draining.
	assign step      = act_q && (!res_valid_q || !res_stall);
	assign last_step = (op_s1 == OP_ARRIVE) || ((ACT_W'(idx_q) + ACT_W'(1)) == act);
	assign req_stall = act_q && !(step && last_step);
	assign req_accept = req_valid && !req_stall;

	// The tick's all-done flag is settled before the first visit: the FIFO
	// is empty and no enabled server is mid-service. An arrive always leaves
	// the FIFO non-empty, so its flag is clear.
	assign done_sel = (op_s1 == OP_ARRIVE) ? 1'b0 :
		(idx_q == '0) ? (q_st.empty && !s_view.any_serving) : done_q;

	assign start_end = tick_q + head_len;

	always_comb begin
		if (op_s1 == OP_ARRIVE) begin
			ev     = q_st.full ? EV_DROPPED : EV_QUEUED;
			ev_id  = id_s1;
			ev_end = 16'd0;
		end else if (!s_view.need) begin
			ev     = EV_SERVING;
			ev_id  = s_view.job;
			ev_end = s_view.end_tk;
		end else if (q_st.empty) begin
			ev     = EV_IDLE;
			ev_id  = 16'd0;
			ev_end = 16'd0;
		end else begin
			ev     = EV_STARTED;
			ev_id  = head_id;
			ev_end = start_end;
		end
	end

	assign q_cmd.push = step && (op_s1 == OP_ARRIVE) && !q_st.full;
	assign q_cmd.pop  = step && (op_s1 == OP_TICK) && s_view.need && !q_st.empty;

	assign s_cmd.visit  = step && (op_s1 == OP_TICK);
	assign s_cmd.start  = !q_st.empty;
	assign s_cmd.idx    = idx_q;
	assign s_cmd.id     = head_id;
	assign s_cmd.len    = head_len;
	assign s_cmd.end_tk = start_end;

	fms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.push_id  (id_s1),
		.push_len (len_s1),
		.st       (q_st),
		.head_id  (head_id),
		.head_len (head_len)
	);

	fms_servers u_servers (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (s_cmd),
		.act    (act),
		.view   (s_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 2'd3;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// Sequencer: take a request, walk the servers, drop it after its last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			idx_q  <= '0;
			done_q <= 1'b0;
			tick_q <= '0;
		end else begin
			if (req_accept) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (step && last_step) begin
				act_q <= 1'b0;
			end else if (step) begin
				idx_q <= idx_q + SRV_W'(1);
			end
			if (step) begin
				done_q <= done_sel;
			end
			if (step && last_step && (op_s1 == OP_TICK)) begin
				tick_q <= tick_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_s1  <= opcode;
			id_s1  <= job_id;
			len_s1 <= service_len;
		end
	end

	// Result register: load on a step, clear once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_idx_q  <= (op_s1 == OP_ARRIVE) ? 2'd0 : 2'(idx_q);
			res_ev_q   <= ev;
			res_id_q   <= ev_id;
			res_end_q  <= ev_end;
			res_now_q  <= tick_q;
			res_done_q <= done_sel;
			res_last_q <= last_step;
		end
	end

	assign res_valid    = res_valid_q;
	assign server_index = res_idx_q;
	assign event_res    = res_ev_q;
	assign served_id    = res_id_q;
	assign end_time     = res_end_q;
	assign now_time     = res_now_q;
	assign all_done     = res_done_q;
	assign last         = res_last_q;

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_cmd.pop |-> !q_st.empty)
		else $error("FIFO popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_cmd.push |-> !q_st.full)
		else $error("FIFO pushed while full");

	a_started_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && ((event_res == EV_STARTED) || (event_res == EV_SERVING)))
		|-> !all_done)
		else $error("all_done set on a result with a busy server");

	a_arrive_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && ((event_res == EV_QUEUED) || (event_res == EV_DROPPED)))
		|-> (last && (server_index == 2'd0)))
		else $error("arrive result not final or not on server zero");
`endif

endmodule
`default_nettype wire
